FILE: rtl/core/aide_pkg.sv
// ----------------------------------------------------------------------------
// aide_pkg
// Shared widths, operation and status codes, and the result word type for
// the array insert/delete engine.
// ----------------------------------------------------------------------------
package aide_pkg;

  localparam int unsigned DepthDef  = 64;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PosW      = 7;
  localparam int unsigned StatW     = 3;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;

  typedef enum logic [FuncW-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_DUMP   = 2'd2
  } func_e;

  typedef enum logic [StatW-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_DELETED  = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_REJECTED = 3'd3,
    STAT_ELEMENT  = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] element;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    logic              last;
  } res_t;

endpackage

FILE: rtl/core/array_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// array_insert_delete_engine
// Packed array of signed words with insert at position, delete by value and
// full dump, held in one synchronous memory.
//
//   channel   dir  tdata                                   tuser    tlast
//   s_axis    in   value[31:0] position[38:32]             func     -
//   m_axis    out  element[31:0] slot[37:32] count[44:38]  status   last
//
// Inserts shift up the entries from the position, deletes search all held
// entries and dumps read them all; the single memory port pair walks one
// entry per cycle, in a dump only while m_axis does not stall.
// Rejected inserts, empty dumps skip the walk; unused opcodes give no result.
// Reset clears the element count; no clearing pass over the store.
// A new word is accepted while the last result still waits on m_axis.
// ----------------------------------------------------------------------------
module array_insert_delete_engine
  import aide_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,  // value, position
  input  logic [FuncW-1:0]     s_axis_tuser_i,  // func
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,  // element, slot, count
  output logic [StatW-1:0]     m_axis_tuser_o,  // status
  output logic                 m_axis_tlast_o
);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ValueW-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ValueW-1:0] mem_rdata;
  res_t              res;

  aide_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_value_i  (s_axis_tdata_i[ValueW-1:0]),
    .in_pos_i    (s_axis_tdata_i[ValueW+PosW-1:ValueW]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  aide_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata_o = {
    (OutTdataW - ValueW - SlotW - CountW)'(0), res.count, res.slot, res.element
  };
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

endmodule

FILE: rtl/core/aide_mem.sv
// ----------------------------------------------------------------------------
// aide_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aide_mem
  import aide_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [DEPTH];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/aide_seq.sv
// ----------------------------------------------------------------------------
// aide_seq
// Operation sequencer: walks the store one entry per cycle for shifts,
// searches and dumps (bar output stalls), keeps the count and result register.
// ----------------------------------------------------------------------------
module aide_seq
  import aide_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FuncW-1:0]  in_func_i,
  input  logic [ValueW-1:0] in_value_i,
  input  logic [PosW-1:0]   in_pos_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [ValueW-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [ValueW-1:0] mem_rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS   = 6'b000010,
    S_INSWR = 6'b000100,
    S_DEL   = 6'b001000,
    S_DUMP  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     paddr_q, paddr_d;
  logic              found_q, found_d;
  logic [AW-1:0]     at_q, at_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [AW-1:0]     pos_q, pos_d;
  status_e           rstat_q, rstat_d;
  logic [AW-1:0]     rslot_q, rslot_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    paddr_d     = paddr_q;
    found_d     = found_q;
    at_d        = at_q;
    val_d       = val_q;
    pos_d       = pos_q;
    rstat_d     = rstat_q;
    rslot_d     = rslot_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = paddr_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d  = in_value_i;
          pos_d  = in_pos_i[AW-1:0];
          pend_d = 1'b0;
          case (func_e'(in_func_i))
            FN_INSERT: begin
              if (in_pos_i > PosW'(fill_q) || fill_q >= CW'(DEPTH)) begin
                rstat_d = STAT_REJECTED;
                rslot_d = '0;
                state_d = S_RESP;
              end else begin
                ptr_d   = AW'(fill_q - CW'(1));
                cnt_d   = fill_q - CW'(in_pos_i);
                state_d = S_INS;
              end
            end
            FN_DELETE: begin
              ptr_d   = '0;
              cnt_d   = fill_q;
              found_d = 1'b0;
              state_d = S_DEL;
            end
            FN_DUMP: begin
              if (fill_q == '0) begin
                rstat_d = STAT_EMPTY;
                rslot_d = '0;
                state_d = S_RESP;
              end else begin
                ptr_d   = '0;
                cnt_d   = fill_q;
                state_d = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      // shift up: read entry i, write it to i+1 next cycle
      S_INS: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = paddr_q;
        end
        if (cnt_q != '0) begin
          mem_re_o = 1'b1;
          paddr_d  = ptr_q + AW'(1);
          ptr_d    = ptr_q - AW'(1);
          cnt_d    = cnt_q - CW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INSWR;
        end
      end

      S_INSWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        fill_d      = fill_q + CW'(1);
        rstat_d     = STAT_INSERTED;
        rslot_d     = pos_q;
        state_d     = S_RESP;
      end

      // search, then the same reads move later entries down by one
      S_DEL: begin
        if (pend_q) begin
          if (found_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = paddr_q - AW'(1);
          end else if (mem_rdata_i == val_q) begin
            found_d = 1'b1;
            at_d    = paddr_q;
          end
        end
        if (cnt_q != '0) begin
          mem_re_o = 1'b1;
          paddr_d  = ptr_q;
          ptr_d    = ptr_q + AW'(1);
          cnt_d    = cnt_q - CW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (found_q) begin
              fill_d  = fill_q - CW'(1);
              rstat_d = STAT_DELETED;
              rslot_d = at_q;
            end else begin
              rstat_d = STAT_NOTFOUND;
              rslot_d = '0;
            end
            state_d = S_RESP;
          end
        end
      end

      S_DUMP: begin
        if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d   = 1'b1;
            out_d.status  = STAT_ELEMENT;
            out_d.element = mem_rdata_i;
            out_d.slot    = SlotW'(paddr_q);
            out_d.count   = CountW'(fill_q);
            out_d.last    = (cnt_q == '0);
          end
          if (cnt_q != '0) begin
            mem_re_o = 1'b1;
            paddr_d  = ptr_q;
            ptr_d    = ptr_q + AW'(1);
            cnt_d    = cnt_q - CW'(1);
            pend_d   = 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = rstat_q;
          out_d.element = '0;
          out_d.slot    = SlotW'(rslot_q);
          out_d.count   = CountW'(fill_q);
          out_d.last    = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    at_q    <= at_d;
    val_q   <= val_d;
    pos_q   <= pos_d;
    rstat_q <= rstat_d;
    rslot_q <= rslot_d;
    out_q   <= out_d;
  end

endmodule

FILE: rtl/core/aide_chk.sv
// ----------------------------------------------------------------------------
// aide_chk
// Port-level checks on the result stream of the array insert/delete engine.
// ----------------------------------------------------------------------------
module aide_chk
  import aide_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic [StatW-1:0]     m_axis_tuser_o,
  input logic                 m_axis_tlast_o
);

  logic [SlotW-1:0]  slot;
  logic [CountW-1:0] count;

  assign slot  = m_axis_tdata_o[ValueW+SlotW-1:ValueW];
  assign count = m_axis_tdata_o[ValueW+SlotW+CountW-1:ValueW+SlotW];

  // single-result operations always close the word group
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != STAT_ELEMENT |-> m_axis_tlast_o)
    else $error("non-element result without tlast");

  // dump words: last exactly on the final held element
  a_dump_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_ELEMENT |->
      (m_axis_tlast_o == (({1'b0, slot} + 7'd1) == count)))
    else $error("dump tlast does not match slot and count");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_EMPTY |-> count == '0 && slot == '0)
    else $error("empty result with nonzero count or slot");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result word changed");

endmodule

bind array_insert_delete_engine aide_chk u_aide_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: bench/array_insert_delete_engine_test.sv
// ----------------------------------------------------------------------------
// array_insert_delete_engine_test
// Self-checking bench for the array insert/delete engine. A short directed
// table runs through the edge cases: empty dump, delete miss, rejected and
// out-of-range inserts, extreme values, duplicates and the unused opcode.
// Random phases then fill the array to capacity, churn it, and drain it
// again. Every result word is checked against the table or a shadow array.
// Both streams idle at random. One long output hold-off backs the engine up.
// ----------------------------------------------------------------------------
module array_insert_delete_engine_test;
  import aide_pkg::*;

  localparam logic [FuncW-1:0] FnUnused   = 2'd3;
  localparam int unsigned      MaxGap     = 18;
  localparam int unsigned      HoldCycles = 400;
  localparam int unsigned      TargetOps  = 410;
  localparam int unsigned      PhaseLen   = 40;
  localparam int unsigned      TailCycles = 200;
  localparam res_t             NoRes      = '{STAT_INSERTED, 32'd0, 6'd0, 7'd0, 1'b0};

  typedef enum int unsigned {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_e;

  typedef struct {
    logic [FuncW-1:0]  fn;
    logic [ValueW-1:0] val;
    logic [PosW-1:0]   pos;
    bit                typed;
    res_t              res;
  } step_t;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_valid = 1'b0;
  logic [InTdataW-1:0]  s_data  = '0;
  logic [FuncW-1:0]     s_user  = '0;
  logic                 m_ready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic [StatW-1:0]     m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  logic [ValueW-1:0] shadow_mem [DepthDef];
  logic [CountW-1:0] shadow_fill = '0;
  res_t              pending_q [$];

  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned err_cnt  = 0;
  int unsigned n_ops    = 0;
  int unsigned n_ins    = 0;
  int unsigned n_del    = 0;
  int unsigned n_dump   = 0;
  int unsigned n_unused = 0;
  int unsigned n_checked = 0;
  int unsigned n_reject = 0;
  int unsigned n_miss   = 0;
  int unsigned peak_fill = 0;

  step_t plan [22] = '{
    '{FN_DUMP,   32'd0,         7'd0,   1'b1, '{STAT_EMPTY,    32'd0, 6'd0, 7'd0, 1'b1}},
    '{FN_DELETE, 32'd5,         7'd0,   1'b1, '{STAT_NOTFOUND, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{FN_INSERT, 32'd7,         7'd1,   1'b1, '{STAT_REJECTED, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{FN_INSERT, 32'h7FFF_FFFF, 7'd0,   1'b1, '{STAT_INSERTED, 32'd0, 6'd0, 7'd1, 1'b1}},
    '{FN_INSERT, 32'h8000_0000, 7'd0,   1'b1, '{STAT_INSERTED, 32'd0, 6'd0, 7'd2, 1'b1}},
    '{FN_INSERT, 32'hFFFF_FFFF, 7'd2,   1'b1, '{STAT_INSERTED, 32'd0, 6'd2, 7'd3, 1'b1}},
    '{FN_INSERT, 32'd0,         7'd1,   1'b1, '{STAT_INSERTED, 32'd0, 6'd1, 7'd4, 1'b1}},
    '{FnUnused,  32'hFFFF_FFFF, 7'd127, 1'b0, NoRes},
    '{FN_INSERT, 32'h5555_5555, 7'd127, 1'b1, '{STAT_REJECTED, 32'd0, 6'd0, 7'd4, 1'b1}},
    '{FN_INSERT, 32'hAAAA_AAAA, 7'd64,  1'b1, '{STAT_REJECTED, 32'd0, 6'd0, 7'd4, 1'b1}},
    '{FN_DUMP,   32'd0,         7'd0,   1'b0, NoRes},
    '{FN_INSERT, 32'hFFFF_FFFF, 7'd0,   1'b1, '{STAT_INSERTED, 32'd0, 6'd0, 7'd5, 1'b1}},
    '{FN_DELETE, 32'hFFFF_FFFF, 7'd0,   1'b0, NoRes},
    '{FN_DELETE, 32'd12345,     7'd0,   1'b1, '{STAT_NOTFOUND, 32'd0, 6'd0, 7'd4, 1'b1}},
    '{FN_DUMP,   32'd0,         7'd127, 1'b0, NoRes},
    '{FN_DELETE, 32'h8000_0000, 7'd0,   1'b0, NoRes},
    '{FN_INSERT, 32'h1234_5678, 7'd3,   1'b0, NoRes},
    '{FN_INSERT, 32'h2468_ACE0, 7'd4,   1'b0, NoRes},
    '{FN_DELETE, 32'h7FFF_FFFF, 7'd0,   1'b0, NoRes},
    '{FN_DELETE, 32'h2468_ACE0, 7'd0,   1'b0, NoRes},
    '{FN_DUMP,   32'd0,         7'd0,   1'b0, NoRes},
    '{FnUnused,  32'd0,         7'd0,   1'b0, NoRes}
  };

  array_insert_delete_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // shadow of the engine: updates the array and returns the result words
  function automatic void apply_word(input logic [FuncW-1:0] fn, input logic [ValueW-1:0] val,
                                     input logic [PosW-1:0] pos, ref res_t outs[$]);
    bit          hit;
    int unsigned at;
    hit = 1'b0;
    at  = 0;
    outs.delete();
    case (fn)
      FN_INSERT: begin
        if (pos > shadow_fill || shadow_fill >= DepthDef) begin
          outs.push_back('{STAT_REJECTED, 32'd0, 6'd0, shadow_fill, 1'b1});
        end else begin
          for (int i = int'(shadow_fill); i > pos; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[pos] = val;
          shadow_fill++;
          outs.push_back('{STAT_INSERTED, 32'd0, pos[SlotW-1:0], shadow_fill, 1'b1});
        end
      end
      FN_DELETE: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_mem[i] == val) begin
            hit = 1'b1;
            at  = i;
          end
        end
        if (!hit) begin
          outs.push_back('{STAT_NOTFOUND, 32'd0, 6'd0, shadow_fill, 1'b1});
        end else begin
          for (int i = at; i + 1 < shadow_fill; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_fill--;
          outs.push_back('{STAT_DELETED, 32'd0, SlotW'(at), shadow_fill, 1'b1});
        end
      end
      FN_DUMP: begin
        if (shadow_fill == 0) begin
          outs.push_back('{STAT_EMPTY, 32'd0, 6'd0, 7'd0, 1'b1});
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            outs.push_back('{STAT_ELEMENT, shadow_mem[i], SlotW'(i), shadow_fill,
                             (i + 1 == shadow_fill)});
        end
      end
      default: ;
    endcase
  endfunction

  // drive one word from the falling edge, book its results once accepted
  task automatic send_word(input logic [FuncW-1:0] fn, input logic [ValueW-1:0] val,
                           input logic [PosW-1:0] pos, input bit typed, input res_t fixed);
    int unsigned gap;
    res_t        fresh [$];
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, pos, val};
    s_user  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    apply_word(fn, val, pos, fresh);
    if (typed) pending_q.push_back(fixed);
    else foreach (fresh[k]) pending_q.push_back(fresh[k]);
    foreach (fresh[k]) begin
      if (fresh[k].status == STAT_REJECTED) n_reject++;
      if (fresh[k].status == STAT_NOTFOUND) n_miss++;
    end
    case (fn)
      FN_INSERT: n_ins++;
      FN_DELETE: n_del++;
      FN_DUMP:   n_dump++;
      default:   n_unused++;
    endcase
    if (fn != FnUnused) n_ops++;
    if (shadow_fill > peak_fill) peak_fill = 32'(shadow_fill);
    @(negedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ValueW'($urandom_range(0, 7)) - 32'd3;
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'd0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [FuncW-1:0] pick_op(input mix_e mix);
    int unsigned r;
    int unsigned ins_pct;
    int unsigned del_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_pct = 80; del_pct = 6;  end
      MIX_CHURN: begin ins_pct = 42; del_pct = 36; end
      default:   begin ins_pct = 16; del_pct = 64; end
    endcase
    if (r < ins_pct) return FN_INSERT;
    if (r < ins_pct + del_pct) return FN_DELETE;
    if (r < 96) return FN_DUMP;
    return FnUnused;
  endfunction

  initial begin : stimulus
    mix_e              mixes [6];
    mix_e              mix;
    int unsigned       phase;
    logic [FuncW-1:0]  fn;
    logic [ValueW-1:0] val;
    logic [PosW-1:0]   pos;
    mixes = '{MIX_FILL, MIX_FILL, MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_DRAIN};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) send_word(plan[k].fn, plan[k].val, plan[k].pos, plan[k].typed, plan[k].res);

    phase = 0;
    while (n_ops + n_unused < TargetOps) begin
      mix  = mixes[phase % 6];
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      for (int unsigned k = 0; k < PhaseLen && n_ops + n_unused < TargetOps; k++) begin
        fn  = pick_op(mix);
        val = pick_value();
        pos = PosW'($urandom_range(0, 127));
        if (fn == FN_INSERT && $urandom_range(0, 99) < 85)
          pos = PosW'($urandom_range(0, shadow_fill));
        if (fn == FN_DELETE && shadow_fill > 0 && $urandom_range(0, 99) < 70)
          val = shadow_mem[$urandom_range(0, shadow_fill - 1)];
        send_word(fn, val, pos, 1'b0, NoRes);
      end
      phase++;
    end
    s_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_q.size() != 0)
      flag($sformatf("%0d result words never arrived", pending_q.size()));
    $display("Ran %0d words: %0d inserts, %0d deletes, %0d dumps, %0d unused ops; %0d results",
             n_ops + n_unused, n_ins, n_del, n_dump, n_unused, n_checked);
    $display("Peak fill %0d of %0d, %0d rejected inserts, %0d delete misses, %0d errors",
             peak_fill, DepthDef, n_reject, n_miss, err_cnt);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    res_t        got;
    res_t        want;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MaxGap);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      got.status  = status_e'(m_axis_tuser_o);
      got.element = m_axis_tdata_o[31:0];
      got.slot    = m_axis_tdata_o[37:32];
      got.count   = m_axis_tdata_o[44:38];
      got.last    = m_axis_tlast_o;
      n_checked++;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected word: status %0d element %h slot %0d count %0d last %0b",
                       got.status, got.element, got.slot, got.count, got.last));
      end else begin
        want = pending_q.pop_front();
        if (got.status != want.status || got.element != want.element ||
            got.slot != want.slot || got.count != want.count || got.last != want.last)
          flag($sformatf({"mismatch: exp status %0d element %h slot %0d count %0d last %0b, ",
                          "got status %0d element %h slot %0d count %0d last %0b"},
                         want.status, want.element, want.slot, want.count, want.last,
                         got.status, got.element, got.slot, got.count, got.last));
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
